// ===== rtl/core/sm3bc_pkg.sv =====
// ----------------------------------------------------------------------------
// sm3bc_pkg
// shared types, constants and controller-to-datapath commands for the
// sm3 block compression engine
// ----------------------------------------------------------------------------
package sm3bc_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLK_WORDS  = 16;
  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned ROUNDS     = 64;
  localparam int unsigned LOW_ROUNDS = 16;

  localparam int unsigned CNT_W   = $clog2(BLK_WORDS);
  localparam int unsigned RND_W   = $clog2(ROUNDS);
  localparam int unsigned WIDX_W  = $clog2(HASH_WORDS);

  // round constant for rounds 0..15 and for rounds 16..63
  localparam logic [WORD_W-1:0] T_LOW  = 32'h79cc4519;
  localparam logic [WORD_W-1:0] T_HIGH = 32'h7a879d8a;
  // t_high rotated left by 16, the value used in round 16
  localparam logic [WORD_W-1:0] T_HIGH_R16 = {T_HIGH[15:0], T_HIGH[31:16]};

  localparam logic [WORD_W-1:0] SM3_IV [HASH_WORDS] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef struct packed {
    logic [WORD_W-1:0] msg_word;
    logic              start_message;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] hash_word;
    logic [WIDX_W-1:0] word_number;
    logic              last_of_block;
  } out_req_t;

  typedef struct packed {
    logic word_shift;   // shift an accepted word into the schedule window
    logic iv_load;      // reload the chaining value from the iv
    logic vars_load;    // load a..h and the round constant for round 0
    logic round_en;     // run one compression round
    logic low_round;    // current round lies in 0..15
    logic t_switch;     // last low round: next constant is t_high rot 16
    logic fold;         // xor a..h into the chaining value, fill output buffer
    logic out_shift;    // step the output buffer by one word
  } dp_cmd_t;

endpackage

// ===== rtl/core/sm3bc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sm3bc_ctrl
// sequencer: word counting, round counting, fold and output emission
// ----------------------------------------------------------------------------
module sm3bc_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               start_message,
  output logic                               busy,
  output logic                               out_valid,
  output logic [sm3bc_pkg::WIDX_W-1:0]       word_number,
  output logic                               last_of_block,
  output sm3bc_pkg::dp_cmd_t                 cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FOLD  = 3'b100
  } state_t;

  state_t                            state_r, state_nxt;
  logic [sm3bc_pkg::CNT_W-1:0]       word_cnt_r, word_cnt_nxt;
  logic [sm3bc_pkg::RND_W-1:0]       round_r, round_nxt;
  logic                              emit_r, emit_nxt;
  logic [sm3bc_pkg::WIDX_W-1:0]      emit_cnt_r, emit_cnt_nxt;
  logic                              accept;
  logic [sm3bc_pkg::CNT_W-1:0]       word_idx;
  logic                              blk_done;

  localparam logic [sm3bc_pkg::CNT_W-1:0]  LAST_WORD =
    sm3bc_pkg::CNT_W'(sm3bc_pkg::BLK_WORDS - 1);
  localparam logic [sm3bc_pkg::RND_W-1:0]  LAST_ROUND =
    sm3bc_pkg::RND_W'(sm3bc_pkg::ROUNDS - 1);
  localparam logic [sm3bc_pkg::RND_W-1:0]  LAST_LOW =
    sm3bc_pkg::RND_W'(sm3bc_pkg::LOW_ROUNDS - 1);
  localparam logic [sm3bc_pkg::WIDX_W-1:0] LAST_OUT =
    sm3bc_pkg::WIDX_W'(sm3bc_pkg::HASH_WORDS - 1);

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  // a start flag makes this word the first of a fresh block
  assign word_idx = start_message ? '0 : word_cnt_r;
  assign blk_done = accept && (word_idx == LAST_WORD);

  always_comb begin
    state_nxt    = state_r;
    word_cnt_nxt = word_cnt_r;
    round_nxt    = round_r;
    emit_nxt     = emit_r;
    emit_cnt_nxt = emit_cnt_r;
    cmd          = '0;

    cmd.word_shift = accept;
    cmd.iv_load    = accept && start_message;

    if (emit_r) begin
      cmd.out_shift = 1'b1;
      emit_cnt_nxt  = emit_cnt_r + 1'b1;
      if (emit_cnt_r == LAST_OUT) begin
        emit_nxt = 1'b0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          word_cnt_nxt = word_idx + 1'b1;
          if (blk_done) begin
            cmd.vars_load = 1'b1;
            round_nxt     = '0;
            state_nxt     = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd.round_en  = 1'b1;
        cmd.low_round = (round_r <= LAST_LOW);
        cmd.t_switch  = (round_r == LAST_LOW);
        round_nxt     = round_r + 1'b1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold     = 1'b1;
        emit_nxt     = 1'b1;
        emit_cnt_nxt = '0;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      word_cnt_r <= '0;
      round_r    <= '0;
      emit_r     <= 1'b0;
      emit_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      word_cnt_r <= word_cnt_nxt;
      round_r    <= round_nxt;
      emit_r     <= emit_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  assign out_valid     = emit_r;
  assign word_number   = emit_cnt_r;
  assign last_of_block = (emit_cnt_r == LAST_OUT);

endmodule

// ===== rtl/core/sm3bc_datapath.sv =====
// ----------------------------------------------------------------------------
// sm3bc_datapath
// schedule window, round function, chaining value and output buffer
// ----------------------------------------------------------------------------
module sm3bc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sm3bc_pkg::dp_cmd_t                 cmd,
  input  logic [sm3bc_pkg::WORD_W-1:0]       msg_word,
  output logic [sm3bc_pkg::WORD_W-1:0]       hash_word
);

  localparam int unsigned W  = sm3bc_pkg::WORD_W;
  localparam int unsigned NB = sm3bc_pkg::BLK_WORDS;
  localparam int unsigned NH = sm3bc_pkg::HASH_WORDS;

  function automatic logic [W-1:0] rotl(input logic [W-1:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (W - n));
  endfunction

  function automatic logic [W-1:0] p0(input logic [W-1:0] v);
    p0 = v ^ rotl(v, 9) ^ rotl(v, 17);
  endfunction

  function automatic logic [W-1:0] p1(input logic [W-1:0] v);
    p1 = v ^ rotl(v, 15) ^ rotl(v, 23);
  endfunction

  // window holds w[r..r+15] during round r
  logic [W-1:0] win_r   [NB];
  logic [W-1:0] win_nxt [NB];
  logic [W-1:0] var_r   [NH];
  logic [W-1:0] var_nxt [NH];
  logic [W-1:0] chain_r [NH];
  logic [W-1:0] chain_nxt [NH];
  logic [W-1:0] obuf_r  [NH];
  logic [W-1:0] obuf_nxt [NH];
  logic [W-1:0] tj_r, tj_nxt;

  logic [W-1:0] w_new, a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    w_new = p1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 15))
            ^ rotl(win_r[3], 7) ^ win_r[10];
    a12   = rotl(var_r[0], 12);
    ss1   = rotl(a12 + var_r[4] + tj_r, 7);
    ss2   = ss1 ^ a12;
    if (cmd.low_round) begin
      ff = var_r[0] ^ var_r[1] ^ var_r[2];
      gg = var_r[4] ^ var_r[5] ^ var_r[6];
    end else begin
      ff = (var_r[0] & var_r[1]) | (var_r[0] & var_r[2]) | (var_r[1] & var_r[2]);
      gg = (var_r[4] & var_r[5]) | (~var_r[4] & var_r[6]);
    end
    tt1 = ff + var_r[3] + ss2 + (win_r[0] ^ win_r[4]);
    tt2 = gg + var_r[7] + ss1 + win_r[0];
  end

  always_comb begin
    win_nxt   = win_r;
    var_nxt   = var_r;
    chain_nxt = chain_r;
    obuf_nxt  = obuf_r;
    tj_nxt    = tj_r;

    if (cmd.word_shift || cmd.round_en) begin
      for (int i = 0; i < NB - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[NB-1] = cmd.round_en ? w_new : msg_word;
    end

    if (cmd.iv_load) begin
      chain_nxt = sm3bc_pkg::SM3_IV;
    end

    if (cmd.vars_load) begin
      var_nxt = chain_r;
      tj_nxt  = sm3bc_pkg::T_LOW;
    end else if (cmd.round_en) begin
      var_nxt[0] = tt1;
      var_nxt[1] = var_r[0];
      var_nxt[2] = rotl(var_r[1], 9);
      var_nxt[3] = var_r[2];
      var_nxt[4] = p0(tt2);
      var_nxt[5] = var_r[4];
      var_nxt[6] = rotl(var_r[5], 19);
      var_nxt[7] = var_r[6];
      tj_nxt     = cmd.t_switch ? sm3bc_pkg::T_HIGH_R16 : rotl(tj_r, 1);
    end

    if (cmd.fold) begin
      for (int i = 0; i < NH; i++) begin
        chain_nxt[i] = chain_r[i] ^ var_r[i];
        obuf_nxt[i]  = chain_r[i] ^ var_r[i];
      end
    end else if (cmd.out_shift) begin
      for (int i = 0; i < NH - 1; i++) begin
        obuf_nxt[i] = obuf_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= sm3bc_pkg::SM3_IV;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    var_r  <= var_nxt;
    obuf_r <= obuf_nxt;
    tj_r   <= tj_nxt;
  end

  assign hash_word = obuf_r[0];

endmodule

// ===== rtl/core/sm3_block_compression.sv =====
// ----------------------------------------------------------------------------
// sm3_block_compression
// sm3 compression engine for already padded 512-bit message blocks
// ----------------------------------------------------------------------------
// Words are taken one per cycle while busy is low, sixteen to a block, most
// significant first; start_message on a word reloads the iv and makes that
// word the first of a fresh block, dropping any partial one. The sixteenth
// word raises busy for 64 rounds at one round per cycle through a single
// round unit with the schedule computed on the fly in a 16-word sliding
// window, then a fold of a..h into the chaining value. The eight chaining
// words then leave from an output buffer one per cycle on out_valid, word 0
// first, last_of_block on word 7; each is shown for exactly one cycle and
// cannot be held off by the receiver. Emission overlaps with taking the next
// block's words. Reset restores the iv and clears the counters.
// ----------------------------------------------------------------------------
module sm3_block_compression (
  input  logic                   clk,
  input  logic                   rst_n,
  // request side
  input  logic                   start,
  output logic                   busy,
  input  sm3bc_pkg::in_req_t     in_req,
  // result side
  output logic                   out_valid,
  output sm3bc_pkg::out_req_t    out_req
);

  sm3bc_pkg::dp_cmd_t                cmd;
  logic [sm3bc_pkg::WIDX_W-1:0]      word_number;
  logic                              last_of_block;
  logic [sm3bc_pkg::WORD_W-1:0]      hash_word;

  // sequencer: word and round counts, emission counter
  sm3bc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .start_message (in_req.start_message),
    .busy          (busy),
    .out_valid     (out_valid),
    .word_number   (word_number),
    .last_of_block (last_of_block),
    .cmd           (cmd)
  );

  // round logic, schedule window and chaining value
  sm3bc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .msg_word  (in_req.msg_word),
    .hash_word (hash_word)
  );

  // result assembled from buffer head and emission count
  always_comb begin
    out_req.hash_word     = hash_word;
    out_req.word_number   = word_number;
    out_req.last_of_block = last_of_block;
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sm3 block compression engine
// ----------------------------------------------------------------------------
// Padded message words go in one request at a time over the start/busy
// handshake. A bit-accurate sm3 compression model in this file predicts the
// eight chaining words of every completed block, and each strobed output word
// is compared field by field with the oldest prediction. Stimulus opens with a
// restart in the middle of a block. Random messages follow: whole blocks,
// chained blocks without a start flag, and broken partial blocks. They run
// under several sender idling patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sm3bc_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_req_t out_req;

  sm3_block_compression u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_req   (out_req)
  );

  // model state: chaining value, words of the block being filled, fill count
  logic [WORD_W-1:0] chain_val [HASH_WORDS];
  logic [WORD_W-1:0] blk_words [BLK_WORDS];
  int unsigned       blk_fill;

  // chaining words still owed by the engine, oldest first
  out_req_t hash_words_due [$];

  int unsigned mismatches;
  int unsigned words_taken;
  int unsigned idle_pct;   // chance in a hundred that the sender idles in a cycle
  bit          start_drv;  // value last scheduled on start

  // --------------------------------------------------------------------------
  // clock, run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // a correct run ends well before this limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sm3 compression model
  // --------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    int k;
    k = n % 32;
    return (x << k) | (x >> (32 - k));
  endfunction

  // expands the current block, runs 64 rounds and folds into the chaining value
  function automatic void sm3_compress();
    logic [WORD_W-1:0] w [68];
    logic [WORD_W-1:0] v [HASH_WORDS];
    logic [WORD_W-1:0] a12, tc, ss1, ss2, ff, gg, tt1, tt2, x;
    int r;
    for (r = 0; r < 16; r++) w[r] = blk_words[r];
    for (r = 16; r < 68; r++) begin
      x = w[r-16] ^ w[r-9] ^ rotl(w[r-3], 15);
      w[r] = x ^ rotl(x, 15) ^ rotl(x, 23) ^ rotl(w[r-13], 7) ^ w[r-6];
    end
    for (r = 0; r < HASH_WORDS; r++) v[r] = chain_val[r];
    for (r = 0; r < ROUNDS; r++) begin
      a12 = rotl(v[0], 12);
      tc  = (r < LOW_ROUNDS) ? T_LOW : T_HIGH;
      ss1 = rotl(a12 + v[4] + rotl(tc, r), 7);
      ss2 = ss1 ^ a12;
      if (r < LOW_ROUNDS) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[r] ^ w[r+4]);
      tt2 = gg + v[7] + ss1 + w[r];
      v[3] = v[2];
      v[2] = rotl(v[1], 9);
      v[1] = v[0];
      v[0] = tt1;
      v[7] = v[6];
      v[6] = rotl(v[5], 19);
      v[5] = v[4];
      v[4] = tt2 ^ rotl(tt2, 9) ^ rotl(tt2, 17);
    end
    for (r = 0; r < HASH_WORDS; r++) chain_val[r] ^= v[r];
  endfunction

  // takes one accepted word into the model, queueing chaining words on block end
  function automatic void absorb_word(input logic [WORD_W-1:0] word, input logic first);
    out_req_t hw;
    int k;
    if (first) begin
      for (k = 0; k < HASH_WORDS; k++) chain_val[k] = SM3_IV[k];
      blk_fill = 0;
    end
    blk_words[blk_fill] = word;
    blk_fill++;
    if (blk_fill == BLK_WORDS) begin
      blk_fill = 0;
      sm3_compress();
      for (k = 0; k < HASH_WORDS; k++) begin
        hw.hash_word     = chain_val[k];
        hw.word_number   = k[WIDX_W-1:0];
        hw.last_of_block = (k == HASH_WORDS - 1);
        hash_words_due.push_back(hw);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // output checker: every strobed word must match the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_hash_words
    out_req_t due;
    if (rst_n && out_valid) begin
      if (hash_words_due.size() == 0) begin
        $error("unexpected output word %h (word_number %0d)",
               out_req.hash_word, out_req.word_number);
        mismatches++;
      end else begin
        due = hash_words_due.pop_front();
        if (out_req.hash_word !== due.hash_word) begin
          $error("hash_word: expected %h, got %h", due.hash_word, out_req.hash_word);
          mismatches++;
        end
        if (out_req.word_number !== due.word_number) begin
          $error("word_number: expected %0d, got %0d",
                 due.word_number, out_req.word_number);
          mismatches++;
        end
        if (out_req.last_of_block !== due.last_of_block) begin
          $error("last_of_block: expected %b, got %b",
                 due.last_of_block, out_req.last_of_block);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  task automatic lower_start();
    if (start_drv) begin
      start     <= 1'b0;
      start_drv = 1'b0;
    end
  endtask

  // idle cycles after a request, each cycle idle with the phase's chance
  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      lower_start();
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // one request: held until an edge sees busy low, then fed to the model
  task automatic send_word(input logic [WORD_W-1:0] word, input logic first);
    start     <= 1'b1;
    start_drv = 1'b1;
    in_req    <= '{msg_word: word, start_message: first};
    do @(posedge clk); while (busy);
    absorb_word(word, first);
    words_taken++;
    sender_gap();
  endtask

  // sender holds off until every owed chaining word has come out
  task automatic drain_hash_words();
    lower_start();
    while (hash_words_due.size() != 0) @(posedge clk);
  endtask

  // word content: random, all zero, all ones or a single set bit
  function automatic logic [WORD_W-1:0] block_word(input int unsigned kind);
    case (kind)
      0:       return $urandom;
      1:       return '0;
      2:       return '1;
      default: return 32'h1 << $urandom_range(31);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // five words chaining from the reset iv, then a start flag mid-block drops
  // them and opens a fresh block of alternating all-zero and all-one words
  task automatic test_restart_mid_block();
    int i;
    idle_pct = 0;
    for (i = 0; i < 5; i++) send_word(block_word(i % 4), 1'b0);
    for (i = 0; i < BLK_WORDS; i++) send_word((i % 2) ? '1 : '0, i == 0);
  endtask

  // random messages: mostly whole blocks with a start on the first word, some
  // chaining on without a start, some broken off part way through a block
  task automatic test_random_messages(input int unsigned pct, input int unsigned n_words);
    int unsigned target, sel, n_blk, len, kind;
    int b, i;
    idle_pct = pct;
    target   = words_taken + n_words;
    while (words_taken < target) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        // partial block, cut off by whatever comes next
        len = $urandom_range(15, 1);
        for (i = 0; (i < len) && (words_taken < target); i++)
          send_word($urandom, (i == 0) && $urandom_range(1));
      end else begin
        n_blk = $urandom_range(3, 1);
        for (b = 0; (b < n_blk) && (words_taken < target); b++) begin
          kind = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
          for (i = 0; (i < BLK_WORDS) && (words_taken < target); i++)
            send_word(block_word(kind), (b == 0) && (i == 0) && (sel >= 25));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    int k;
    rst_n       = 1'b0;
    start       = 1'b0;
    start_drv   = 1'b0;
    in_req      = '0;
    mismatches  = 0;
    words_taken = 0;
    idle_pct    = 0;
    blk_fill    = 0;
    for (k = 0; k < HASH_WORDS; k++) chain_val[k] = SM3_IV[k];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_restart_mid_block();
    drain_hash_words();
    test_random_messages(0, 100);
    drain_hash_words();
    test_random_messages(59, 100);
    test_random_messages(7, 100);
    drain_hash_words();
    test_random_messages(0, 90);

    // let the last block finish its rounds and empty the output buffer
    drain_hash_words();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
